### rtl/assert_macros.svh
// Assertion macros for the bit packer RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define HCBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define HCBP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/hcbp_pkg.sv
// Shared constants for the Huffman code bit packer.
// No dependencies; imported by huffman_code_bit_packer_unit and the testbench.
package hcbp_pkg;

	localparam int CMD_W     = 2;
	localparam int SYM_W     = 9;
	localparam int VALUE_W   = 32;
	localparam int LENGTH_W  = 6;
	localparam int BYTE_W    = 8;
	localparam int PEND_W    = 7;
	localparam int PCNT_W    = 3;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

	localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

endpackage

### rtl/huffman_code_bit_packer_unit.sv
// Huffman code bit packer: code table in a synchronous memory plus a byte emitter.
// Depends on hcbp_pkg and assert_macros.svh.
//
// Usage: the slave channel takes one command per transaction. A load writes one
// code table entry (index, length, code bits) and gives no result. An encode
// appends the code of its symbol to the bit accumulator; an end appends the end
// symbol's code and flushes a partial byte, zero padded. Each completed byte
// leaves on the master channel, first bit in bit 7; tlast marks the final result
// of one command. A symbol without a code gives one result with tuser set.
// An accepted command reads the table into the read stage, then enters the emitter
// register, which shows its first result. An item with several results holds the
// single emitter register until its last is taken (up to five on an end with 32-bit
// codes); items of zero or one result pass at one item per cycle while m_tready is high.
// The emitter register separates both sides: the next command is accepted and
// its table read done while the previous bytes still drain.
// Reset: pending bits are cleared and a clearing pass writes zero length into
// every table entry (at most 512), one entry a cycle; tready
// stays low until it ends. A stalled master channel holds the current result and
// the emitter, and the slave side stalls once the table read stage is also full.
`include "assert_macros.svh"

module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_BITS = 32,
	parameter int SYMBOL_COUNT  = 257
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [8:0] symbol, [40:9] code_value, [46:41] code_length, [47] zero
	input  logic [hcbp_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  logic [hcbp_pkg::CMD_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] packed_byte
	output logic [hcbp_pkg::M_DATA_W-1:0] m_tdata,
	// [0] out_kind
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import hcbp_pkg::*;

	localparam int CW     = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
	localparam int LW     = $clog2(CW + 1);
	localparam int DEPTH  = (SYMBOL_COUNT < 512) ? SYMBOL_COUNT : 512;
	localparam int AW     = $clog2(DEPTH);
	localparam int ACC_W  = CW + PEND_W;
	localparam int NB     = (CW + PEND_W + 7) / 8;
	localparam int ALW    = 8 * NB;
	localparam int TOT_W  = $clog2(CW + 8);
	localparam int SH_W   = $clog2(ALW + 1);
	localparam int CNT_W  = $clog2(NB + 2);
	localparam int ENTRY_W = LW + CW;

	// Input field split.
	logic [SYM_W-1:0]    in_symbol;
	logic [VALUE_W-1:0]  in_value;
	logic [LENGTH_W-1:0] in_length;
	logic [CMD_W-1:0]    in_cmd;
	logic                in_accept;
	logic [SYM_W-1:0]    look_sym;
	logic                look_in_range;
	logic                load_in_range;
	logic [LW-1:0]       load_len;
	logic [CW-1:0]       load_code;

	assign in_symbol = s_tdata[SYM_W-1:0];
	assign in_value  = s_tdata[SYM_W+VALUE_W-1:SYM_W];
	assign in_length = s_tdata[SYM_W+VALUE_W+LENGTH_W-1:SYM_W+VALUE_W];
	assign in_cmd    = s_tuser;
	assign in_accept = s_tvalid && s_tready;

	assign look_sym      = (in_cmd == CMD_END) ? END_SYMBOL : in_symbol;
	assign look_in_range = 32'(look_sym) < 32'(SYMBOL_COUNT);
	assign load_in_range = 32'(in_symbol) < 32'(SYMBOL_COUNT);

	always_comb begin
		if (32'(in_length) > 32'(CW)) begin
			load_len = LW'(CW);
		end else begin
			load_len = LW'(in_length);
		end
		load_code = in_value[CW-1:0] & ({CW{1'b1}} >> (CW - 32'(load_len)));
	end

	// Clearing pass after reset.
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Code table. Loads write at acceptance, so a following item reads the new entry.
	logic [ENTRY_W-1:0] code_mem [DEPTH];
	logic [ENTRY_W-1:0] rd_s1;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = in_symbol[AW-1:0];
		mem_wdata = {load_len, load_code};
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (in_accept && in_cmd == CMD_LOAD && load_in_range) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			code_mem[mem_waddr] <= mem_wdata;
		end
		if (in_accept) begin
			rd_s1 <= code_mem[look_sym[AW-1:0]];
		end
	end

	// Table read stage.
	logic             s1_v;
	logic [CMD_W-1:0] cmd_s1;
	logic             inr_s1;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1 <= in_cmd;
			inr_s1 <= look_in_range;
		end
	end

	// Pending bits and emitter.
	logic [PEND_W-1:0] pend_bits_q;
	logic [PCNT_W-1:0] pend_cnt_q;
	logic              em_v_q;
	logic              em_err_q;
	logic [CNT_W-1:0]  em_cnt_q;
	logic [ALW-1:0]    em_data_q;

	logic [LW-1:0]     rd_len;
	logic [CW-1:0]     rd_code;
	logic              is_code_cmd;
	logic              is_err;
	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  total;
	logic [PCNT_W-1:0] rem;
	logic              do_flush;
	logic [CNT_W-1:0]  n_res;
	logic [ALW-1:0]    aligned;
	logic [PEND_W-1:0] next_pend;
	logic              em_free;
	logic              s1_go;
	logic              out_accept;

	assign rd_len      = rd_s1[ENTRY_W-1:CW];
	assign rd_code     = rd_s1[CW-1:0];
	assign is_code_cmd = (cmd_s1 == CMD_ENCODE) || (cmd_s1 == CMD_END);
	assign is_err      = is_code_cmd && (!inr_s1 || rd_len == '0);

	always_comb begin
		acc       = (ACC_W'(pend_bits_q) << rd_len) | ACC_W'(rd_code);
		total     = TOT_W'(pend_cnt_q) + TOT_W'(rd_len);
		rem       = total[PCNT_W-1:0];
		do_flush  = (cmd_s1 == CMD_END) && (rem != '0);
		aligned   = ALW'(acc) << (SH_W'(ALW) - SH_W'(total));
		next_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
		if (!is_code_cmd) begin
			n_res = '0;
		end else if (is_err) begin
			n_res = CNT_W'(1);
		end else begin
			n_res = CNT_W'(total >> 3) + CNT_W'(do_flush);
		end
	end

	assign out_accept = m_tvalid && m_tready;
	assign em_free    = !em_v_q || (m_tready && em_cnt_q == CNT_W'(1));
	assign s1_go      = s1_v && (n_res == '0 || em_free);
	assign s_tready   = !clr_q && (!s1_v || s1_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v        <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			em_v_q      <= 1'b0;
			em_cnt_q    <= '0;
		end else begin
			if (in_accept) begin
				s1_v <= 1'b1;
			end else if (s1_go) begin
				s1_v <= 1'b0;
			end
			if (s1_go && is_code_cmd && !is_err) begin
				pend_bits_q <= (cmd_s1 == CMD_END) ? '0 : next_pend;
				pend_cnt_q  <= (cmd_s1 == CMD_END) ? '0 : rem;
			end
			if (s1_go && n_res != '0) begin
				em_v_q   <= 1'b1;
				em_cnt_q <= n_res;
			end else if (out_accept) begin
				em_cnt_q <= em_cnt_q - 1'b1;
				if (em_cnt_q == CNT_W'(1)) begin
					em_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && n_res != '0) begin
			em_err_q  <= is_err;
			em_data_q <= is_err ? '0 : aligned;
		end else if (out_accept) begin
			em_data_q <= em_data_q << 8;
		end
	end

	assign m_tvalid = em_v_q;
	assign m_tdata  = em_data_q[ALW-1 -: M_DATA_W];
	assign m_tuser  = em_err_q ? KIND_ERROR : KIND_BYTE;
	assign m_tlast  = em_cnt_q == CNT_W'(1);

	`HCBP_ASSERT(a_no_accept_in_clear, clr_q |-> !s_tready, "item accepted during table clear")
	`HCBP_ASSERT(a_err_single_zero, (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0),
		"error result not single and zero")
	`HCBP_ASSERT(a_em_count_live, em_v_q |-> (em_cnt_q != '0), "emitter valid with no results left")
	`HCBP_ASSERT(a_s1_holds, (s1_v && !s1_go) |=> s1_v, "read stage dropped a stalled item")
	`HCBP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!m_tvalid && !s_tready),
		"handshake active in reset")

endmodule

### test/testbench.sv
// Self-checking testbench for huffman_code_bit_packer_unit.
// Depends on hcbp_pkg; drives the command stream, predicts the packed bytes and
// compares them with the master stream under random idling on both sides.
module testbench;
	import hcbp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CODE_BITS_MAX = 32;
	localparam int TABLE_SIZE    = 257;
	localparam int RANDOM_ITEMS  = 275;
	localparam int IDLE_LIMIT    = 5000;
	localparam int POOL_SIZE     = 12;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} packer_result_t;

	// Mirrors the code table and bit accumulator and queues the bytes they imply.
	class packer_scoreboard;
		logic [VALUE_W-1:0]  code_bits [TABLE_SIZE];
		logic [LENGTH_W-1:0] code_len [TABLE_SIZE];
		logic [PEND_W-1:0]   carry_bits;
		int                  carry_count;
		logic [BYTE_W-1:0]   fresh_bytes[$];
		packer_result_t      expected_bytes[$];

		function new();
			for (int i = 0; i < TABLE_SIZE; i++) begin
				code_bits[i] = '0;
				code_len[i] = '0;
			end
			carry_bits = '0;
			carry_count = 0;
		endfunction

		// Appends the code of one symbol; returns 0 when the symbol has no code.
		function bit append_code(logic [SYM_W-1:0] idx, bit flush);
			logic [63:0] acc;
			int          len;
			int          total;
			fresh_bytes.delete();
			if (idx >= TABLE_SIZE || code_len[idx] == 0)
				return 0;
			len = code_len[idx];
			acc = ({57'd0, carry_bits} << len) | {32'd0, code_bits[idx]};
			total = carry_count + len;
			while (total >= 8) begin
				fresh_bytes.push_back(BYTE_W'(acc >> (total - 8)));
				total -= 8;
			end
			if (flush && total > 0) begin
				fresh_bytes.push_back(BYTE_W'(acc << (8 - total)));
				total = 0;
			end
			carry_count = total;
			carry_bits = PEND_W'(acc & ((64'd1 << total) - 1));
			return 1;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
				logic [VALUE_W-1:0] value, logic [LENGTH_W-1:0] len);
			logic [LENGTH_W-1:0] stored_len;
			bit                  has_code;
			packer_result_t      res;
			if (cmd == CMD_LOAD) begin
				if (sym < TABLE_SIZE) begin
					stored_len = (len > CODE_BITS_MAX) ? LENGTH_W'(CODE_BITS_MAX) : len;
					code_len[sym] = stored_len;
					code_bits[sym] = value & VALUE_W'((64'd1 << stored_len) - 1);
				end
				return;
			end
			if (cmd == CMD_ENCODE)
				has_code = append_code(sym, 1'b0);
			else if (cmd == CMD_END)
				has_code = append_code(END_SYMBOL, 1'b1);
			else
				return;
			if (!has_code) begin
				res.kind = KIND_ERROR;
				res.data = '0;
				res.last = 1'b1;
				expected_bytes.push_back(res);
				return;
			end
			for (int i = 0; i < fresh_bytes.size(); i++) begin
				res.kind = KIND_BYTE;
				res.data = fresh_bytes[i];
				res.last = (i == fresh_bytes.size() - 1);
				expected_bytes.push_back(res);
			end
		endfunction

		// Returns an empty string on a match, else a description of the mismatch.
		function string check_result(logic kind, logic [BYTE_W-1:0] data, logic last);
			packer_result_t want;
			string          msg;
			if (expected_bytes.size() == 0)
				return $sformatf("unexpected result kind %0d byte %02h last %0d",
					kind, data, last);
			want = expected_bytes.pop_front();
			msg = "";
			if (kind !== want.kind)
				msg = {msg, $sformatf(" kind %0d want %0d", kind, want.kind)};
			if (data !== want.data)
				msg = {msg, $sformatf(" byte %02h want %02h", data, want.data)};
			if (last !== want.last)
				msg = {msg, $sformatf(" last %0d want %0d", last, want.last)};
			if (msg != "")
				msg = {"result mismatch:", msg};
			return msg;
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b1;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]    s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	packer_scoreboard sb = new();
	int               mismatches = 0;
	bit               tx_burst = 1'b0;
	bit               rx_burst = 1'b0;
	logic [SYM_W-1:0] sym_pool [POOL_SIZE];

	huffman_code_bit_packer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic int pick_gap(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [LENGTH_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return LENGTH_W'($urandom_range(33, 63));
		if (r < 25)
			return LENGTH_W'($urandom_range(13, 32));
		return LENGTH_W'($urandom_range(1, 12));
	endfunction

	task automatic send_command(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
			logic [VALUE_W-1:0] value, logic [LENGTH_W-1:0] len);
		int gap;
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {1'b0, len, value, sym};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(cmd, sym, value, len);
		if ($urandom_range(0, 39) == 0)
			tx_burst = ~tx_burst;
	endtask

	// Receiver: runs of ready broken by stalls, with stall-free stretches.
	initial begin
		int run;
		int gap;
		forever begin
			run = $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap(rx_burst);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				rx_burst = ~rx_burst;
		end
	end

	always @(posedge clk) begin : result_monitor
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = sb.check_result(m_tuser, m_tdata, m_tlast);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	// Ends the run when neither side moves a transaction for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int               counted;
		int               r;
		logic [SYM_W-1:0] sym;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, clamping, out-of-range indexes, flushes.
		send_command(CMD_ENCODE, 9'd5, 32'h0, 6'd0);
		send_command(CMD_END, 9'd0, 32'h0, 6'd0);
		send_command(CMD_LOAD, 9'd0, 32'h1, 6'd1);
		send_command(CMD_LOAD, 9'd255, 32'hFFFF_FFFF, 6'd32);
		send_command(CMD_LOAD, END_SYMBOL, 32'h55, 6'd7);
		send_command(CMD_LOAD, 9'd300, 32'h3, 6'd2);
		send_command(CMD_LOAD, 9'd1, 32'hAAAA_AAAA, 6'd40);
		send_command(CMD_LOAD, 9'd2, 32'hFFFF_FFF5, 6'd3);
		send_command(CMD_LOAD, 9'd511, 32'h0, 6'd63);
		send_command(CMD_ENCODE, 9'd0, 32'h0, 6'd0);
		send_command(CMD_ENCODE, 9'd255, 32'h0, 6'd0);
		send_command(CMD_ENCODE, 9'd1, 32'h0, 6'd0);
		send_command(CMD_ENCODE, 9'd2, 32'h0, 6'd0);
		send_command(CMD_UNUSED, 9'd1, $urandom, 6'd5);
		send_command(CMD_ENCODE, 9'd400, 32'h0, 6'd0);
		send_command(CMD_ENCODE, END_SYMBOL, 32'h0, 6'd0);
		send_command(CMD_END, 9'd0, 32'h0, 6'd0);
		send_command(CMD_LOAD, 9'd0, 32'hFFFF_FFFF, 6'd0);
		send_command(CMD_ENCODE, 9'd0, 32'h0, 6'd0);
		send_command(CMD_LOAD, 9'd3, 32'h0, 6'd8);
		send_command(CMD_ENCODE, 9'd3, 32'h0, 6'd0);
		send_command(CMD_LOAD, END_SYMBOL, 32'hFFFF_FFFF, 6'd32);
		send_command(CMD_ENCODE, 9'd2, 32'h0, 6'd0);
		send_command(CMD_ENCODE, 9'd2, 32'h0, 6'd0);
		// Six pending bits plus a 32-bit end code give the longest burst.
		send_command(CMD_END, 9'd0, 32'h0, 6'd0);

		// Random part: a small pool of symbols keeps most encodes hitting codes.
		sym_pool[0] = 9'd0;
		sym_pool[1] = 9'd255;
		sym_pool[2] = END_SYMBOL;
		for (int i = 3; i < POOL_SIZE; i++)
			sym_pool[i] = SYM_W'($urandom_range(1, 254));
		foreach (sym_pool[i])
			send_command(CMD_LOAD, sym_pool[i], $urandom, LENGTH_W'($urandom_range(1, 12)));

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			sym = sym_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (r < 20) begin
				send_command(CMD_LOAD, sym, $urandom, pick_length());
				counted++;
			end else if (r < 23) begin
				send_command(CMD_LOAD, SYM_W'($urandom_range(TABLE_SIZE, 511)), $urandom,
					pick_length());
			end else if (r < 26) begin
				send_command(CMD_UNUSED, SYM_W'($urandom), $urandom, LENGTH_W'($urandom));
			end else if (r < 31) begin
				send_command(CMD_ENCODE, SYM_W'($urandom_range(0, 511)), $urandom,
					LENGTH_W'($urandom));
				counted++;
			end else if (r < 88) begin
				send_command(CMD_ENCODE, sym, $urandom, LENGTH_W'($urandom));
				counted++;
			end else begin
				send_command(CMD_END, SYM_W'($urandom), $urandom, LENGTH_W'($urandom));
				counted++;
			end
		end
		s_tvalid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
